[hdl/zcbf_pkg.sv]
// Shared constants, types and duty clamp for the zero-cross burst-fire driver.
package zcbf_pkg;

    localparam int FRAC_BITS = 14;
    localparam int DUTY_W    = 16;
    localparam int HB_W      = 32;
    localparam int CNT_W     = 32;
    localparam int STALE_W   = 16;

    // Accumulator holds 0 .. 2.0
    localparam int ACC_W = FRAC_BITS + 2;
    localparam int CMP_W = (ACC_W > DUTY_W) ? ACC_W : DUTY_W;

    localparam logic [CMP_W-1:0] ONE_CMP = CMP_W'(1) << FRAC_BITS;
    localparam logic [ACC_W:0]   ONE_SUM = (ACC_W + 1)'(1) << FRAC_BITS;
    localparam logic [ACC_W:0]   TWO_SUM = (ACC_W + 1)'(2) << FRAC_BITS;

    localparam logic [STALE_W-1:0] STALE_MAX       = '1;
    localparam logic [STALE_W-1:0] STALE_LIMIT_RST = STALE_W'(100);

    typedef struct packed {
        logic step;       // a crossing, real or simulated
        logic force_off;  // heartbeat watchdog tripped
    } t_mod_ctl;

    // Clamp a signed duty command to [0, 1.0]
    function automatic logic [ACC_W-1:0] clamp_duty(input logic signed [DUTY_W-1:0] raw);
        logic [CMP_W-1:0] mag;
        mag = CMP_W'($unsigned(raw));
        if (raw[DUTY_W-1]) begin
            return '0;
        end else if (mag > ONE_CMP) begin
            return ONE_CMP[ACC_W-1:0];
        end else begin
            return mag[ACC_W-1:0];
        end
    endfunction

endpackage

[hdl/zcbf_ifs.sv]
// Channel interfaces: event input, result output and configuration write.
interface zcbf_in_if
    import zcbf_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     mode;
    logic                     simulate_crossing;
    logic signed [DUTY_W-1:0] duty_one;
    logic signed [DUTY_W-1:0] duty_two;
    logic [HB_W-1:0]          heartbeat;

    modport source (output valid, mode, simulate_crossing, duty_one, duty_two, heartbeat,
                    input ready);
    modport sink   (input valid, mode, simulate_crossing, duty_one, duty_two, heartbeat,
                    output ready);
endinterface

interface zcbf_out_if
    import zcbf_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             fire_one;
    logic             fire_two;
    logic             alarm;
    logic [CNT_W-1:0] crossing_count;
    logic             frontend_stale;

    modport source (output valid, fire_one, fire_two, alarm, crossing_count, frontend_stale,
                    input ready);
    modport sink   (input valid, fire_one, fire_two, alarm, crossing_count, frontend_stale,
                    output ready);
endinterface

interface zcbf_cfg_if
    import zcbf_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [STALE_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

[hdl/zcbf_chan.sv]
// One relay channel: first-order sigma-delta accumulator with fire decision.
module zcbf_chan
    import zcbf_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_mod_ctl                 i_ctl,
    input  logic signed [DUTY_W-1:0] i_duty,
    output logic                     o_fire
);

    logic [ACC_W-1:0] r_acc;
    logic [ACC_W-1:0] n_acc;
    logic [ACC_W-1:0] w_duty;
    logic [ACC_W:0]   w_sum;
    logic [ACC_W:0]   w_rem;
    logic             w_fire;

    always_comb begin
        w_duty = i_ctl.force_off ? '0 : clamp_duty(i_duty);
        w_sum  = {1'b0, r_acc} + {1'b0, w_duty};
        w_fire = (w_sum >= ONE_SUM);
        w_rem  = w_fire ? (w_sum - ONE_SUM) : w_sum;
        // cap at 2.0
        n_acc  = (w_rem > TWO_SUM) ? TWO_SUM[ACC_W-1:0] : w_rem[ACC_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctl.step) begin
            r_acc <= n_acc;
        end
    end

    assign o_fire = w_fire;

endmodule

[hdl/zero_cross_burst_fire_two_channel.sv]
// Top level of the two-channel zero-cross burst-fire relay driver.
//
// One event item (zero-cross edge or timeout) goes in, one result item comes out.
// An accepted item is held in the input register, then the crossing, watchdog
// and both accumulator updates are worked out combinationally from it and
// land in the output register; a new item is taken every cycle while the
// output is drained. The stale limit is written through the configuration
// channel, which is always ready; write it only while no item is in flight.
module zero_cross_burst_fire_two_channel
    import zcbf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    zcbf_in_if.sink    i_in,
    zcbf_out_if.source o_out,
    zcbf_cfg_if.sink   i_cfg
);

    // input register
    logic                     r_in_valid;
    logic                     r_mode;
    logic                     r_sim;
    logic signed [DUTY_W-1:0] r_duty_one;
    logic signed [DUTY_W-1:0] r_duty_two;
    logic [HB_W-1:0]          r_hb;

    // block state
    logic [STALE_W-1:0] r_stale_limit;
    logic [HB_W-1:0]    r_last_hb;
    logic [HB_W-1:0]    n_last_hb;
    logic [STALE_W-1:0] r_stale_count;
    logic [STALE_W-1:0] n_stale_count;
    logic               r_hb_seen;
    logic               n_hb_seen;
    logic [CNT_W-1:0]   r_crossings;
    logic [CNT_W-1:0]   n_crossings;
    logic               r_alarm_flag;
    logic               n_alarm_flag;

    // output register
    logic               r_out_valid;
    logic               r_fire_one;
    logic               r_fire_two;
    logic               r_alarm;
    logic [CNT_W-1:0]   r_count;
    logic               r_stale;

    logic     w_advance;
    logic     w_work;
    logic     w_timeout;
    logic     w_stale;
    logic     w_fire_one;
    logic     w_fire_two;
    t_mod_ctl w_ctl;

    assign w_advance  = !r_out_valid || o_out.ready;
    assign w_work     = r_in_valid && w_advance;
    assign i_in.ready = !r_in_valid || w_advance;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_mode     <= i_in.mode;
            r_sim      <= i_in.simulate_crossing;
            r_duty_one <= i_in.duty_one;
            r_duty_two <= i_in.duty_two;
            r_hb       <= i_in.heartbeat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stale_limit <= STALE_LIMIT_RST;
        end else if (i_cfg.valid) begin
            r_stale_limit <= i_cfg.data;
        end
    end

    always_comb begin
        w_timeout     = r_mode && !r_sim;
        n_last_hb     = r_last_hb;
        n_stale_count = r_stale_count;
        n_hb_seen     = r_hb_seen;
        n_crossings   = r_crossings;
        n_alarm_flag  = 1'b1;
        if (!w_timeout) begin
            n_crossings  = r_crossings + CNT_W'(1);
            n_alarm_flag = 1'b0;
            if (r_hb != r_last_hb) begin
                n_last_hb     = r_hb;
                n_stale_count = '0;
                n_hb_seen     = 1'b1;
            end else if (r_hb_seen && (r_stale_count != STALE_MAX)) begin
                n_stale_count = r_stale_count + STALE_W'(1);
            end
        end
        w_stale         = !w_timeout && n_hb_seen && (n_stale_count >= r_stale_limit);
        w_ctl.step      = w_work && !w_timeout;
        w_ctl.force_off = w_stale;
    end

    zcbf_chan u_chan_one (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_duty  (r_duty_one),
        .o_fire  (w_fire_one)
    );

    zcbf_chan u_chan_two (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_duty  (r_duty_two),
        .o_fire  (w_fire_two)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_hb     <= '0;
            r_stale_count <= '0;
            r_hb_seen     <= 1'b0;
            r_crossings   <= '0;
            r_alarm_flag  <= 1'b0;
        end else if (w_work) begin
            r_last_hb     <= n_last_hb;
            r_stale_count <= n_stale_count;
            r_hb_seen     <= n_hb_seen;
            r_crossings   <= n_crossings;
            r_alarm_flag  <= n_alarm_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_work) begin
            // relays stay off on a real timeout
            r_fire_one <= w_fire_one && !w_timeout;
            r_fire_two <= w_fire_two && !w_timeout;
            r_alarm    <= n_alarm_flag;
            r_count    <= n_crossings;
            r_stale    <= w_stale;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.fire_one       = r_fire_one;
    assign o_out.fire_two       = r_fire_two;
    assign o_out.alarm          = r_alarm;
    assign o_out.crossing_count = r_count;
    assign o_out.frontend_stale = r_stale;

    // a crossing advances the count by exactly one
    a_cross_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_work && !w_timeout |=> r_crossings == $past(r_crossings) + CNT_W'(1))
        else $error("crossing count did not advance by one");

    // a timeout leaves the count alone and raises the alarm flag
    a_timeout_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_work && w_timeout |=> $stable(r_crossings) && r_alarm_flag)
        else $error("timeout changed crossing count or missed alarm");

    // the watchdog only trips after a heartbeat change was seen
    a_stale_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_stale |-> r_hb_seen && !r_alarm)
        else $error("stale result without heartbeat seen");

    // a held item is never dropped from the input register
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_advance |=> r_in_valid)
        else $error("input item lost while stalled");

endmodule
